/* hw/rtl/bitmap_page_frame_allocator_assert.svh */
// Assertion macros for the page frame allocator checks.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BPFA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpfa check failed");

// Next-cycle implication.
`define BPFA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpfa check failed");

`endif

/* hw/rtl/bpfa_pkg.sv */
package bpfa_pkg;

    localparam int BPFA_NUM_FRAMES = 32768;
    localparam int BPFA_WORD_BITS  = 32;

    localparam int ADDR_W      = 27;
    localparam int FRAME_SHIFT = 12;
    localparam int CFG_W       = 16;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 2;

    // reserved limit default: 0x400000 / 0x1000
    localparam logic [CFG_W-1:0] RESERVED_RESET = 16'd1024;
    localparam logic [CFG_W-1:0] TOP_RESET      = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP      = 2'd1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_OOM   = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

endpackage

/* hw/rtl/bpfa_low_zero.sv */
// Lowest clear bit of a word.
module bpfa_low_zero
    import bpfa_pkg::*;
#(
    parameter int W = BPFA_WORD_BITS
)
(
    input  logic [W-1:0]         word,
    output logic                 found,
    output logic [$clog2(W)-1:0] pos
);

    localparam int PW = $clog2(W);

    logic [W-1:0] zeros;
    logic [W-1:0] lowest;

    assign zeros  = ~word;
    assign lowest = zeros & (~zeros + W'(1));
    assign found  = |zeros;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < W; i++)
        begin
            if (lowest[i])
            begin
                pos = pos | PW'(i);
            end
        end
    end

endmodule

/* hw/rtl/bitmap_page_frame_allocator.sv */
// channel  direction  handshake                payload
// req      in         req_valid / req_stall    operation, address
// rsp      out        rsp_valid / rsp_stall    frame_address, status, allocated_count
// cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// After reset a clearing pass writes every bitmap word (NUM_WORDS, 1024 at defaults)
// with req_stall high; cfg is always ready. Free runs S_FREE then S_DONE; an
// out-of-range free or op 3 goes to S_DONE; init runs S_INIT over every word, S_DONE.
// Alloc reads summary words in S_SCAN to the first non-full one, then S_WORD on a hit.
// A result waits in the rsp register under rsp_stall while the next beat is accepted.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int NUM_FRAMES = BPFA_NUM_FRAMES,
    parameter int WORD_BITS  = BPFA_WORD_BITS   // power of two
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           operation,
    input  logic [ADDR_W-1:0]    address,

    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [ADDR_W-1:0]    frame_address,
    output logic [1:0]           status,
    output logic [COUNT_W-1:0]   allocated_count,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int WSH        = $clog2(WORD_BITS);
    localparam int NUM_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int NUM_SWORDS = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SA         = (NUM_SWORDS > 1) ? $clog2(NUM_SWORDS) : 1;
    localparam int FIW        = WA + WSH;
    localparam int SWW        = SA + WSH;
    localparam int LW         = (FIW + 1 > CFG_W) ? FIW + 1 : CFG_W;
    localparam int EW         = (SWW + WSH + 1 > LW) ? SWW + WSH + 1 : LW;
    localparam int FAW        = (FIW + FRAME_SHIFT > ADDR_W) ? FIW + FRAME_SHIFT : ADDR_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_WORD,
        S_FREE,
        S_DONE
    } state_t;

    state_t               state_reg,       state_next;
    logic [WA-1:0]        sweep_reg,       sweep_next;
    logic [LW-1:0]        sweep_lim_reg,   sweep_lim_next;
    logic [SA-1:0]        sidx_reg,        sidx_next;
    logic [WSH-1:0]       slot_reg,        slot_next;
    logic [WA-1:0]        word_reg,        word_next;
    logic [WSH-1:0]       bit_reg,         bit_next;
    logic [COUNT_W-1:0]   count_reg,       count_next;
    logic [ADDR_W-1:0]    res_faddr_reg,   res_faddr_next;
    logic [1:0]           res_status_reg,  res_status_next;
    logic [CFG_W-1:0]     reserved_reg,    reserved_next;
    logic [CFG_W-1:0]     top_reg,         top_next;
    logic                 rsp_valid_reg,   rsp_valid_next;
    logic [ADDR_W-1:0]    rsp_faddr_reg,   rsp_faddr_next;
    logic [1:0]           rsp_status_reg,  rsp_status_next;
    logic [COUNT_W-1:0]   rsp_count_reg,   rsp_count_next;

    // bitmap and full-word summary
    logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] summary_mem [NUM_SWORDS];
    logic [WORD_BITS-1:0] bm_rdata_reg;
    logic [WORD_BITS-1:0] sm_rdata_reg;
    logic                 bm_we;
    logic [WA-1:0]        bm_waddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic [WA-1:0]        bm_raddr;
    logic                 sm_we;
    logic [SA-1:0]        sm_waddr;
    logic [WORD_BITS-1:0] sm_wdata;
    logic [SA-1:0]        sm_raddr;

    logic [LW-1:0]        top_lim;
    logic [LW-1:0]        res_lim;
    logic                 s_found;
    logic [WSH-1:0]       s_pos;
    logic                 b_found;
    logic [WSH-1:0]       b_pos;
    logic [SWW-1:0]       cand_word;
    logic [FIW-1:0]       cand_frame;
    logic [FAW-1:0]       cand_faddr;
    logic [WORD_BITS-1:0] bm_set_word;
    logic [LW-1:0]        free_idx;
    logic [FIW-1:0]       free_frame;
    logic [SWW-1:0]       free_word;
    logic [LW-1:0]        sweep_base;

    function automatic logic [WORD_BITS-1:0] head_mask(
        input logic [LW-1:0] lim,
        input logic [LW-1:0] base
    );
        logic [LW-1:0] rem;
        logic [WORD_BITS-1:0] mask;
        rem = lim - base;
        if (lim <= base)
        begin
            mask = '0;
        end
        else if (rem >= LW'(WORD_BITS))
        begin
            mask = '1;
        end
        else
        begin
            mask = ~({WORD_BITS{1'b1}} << rem[WSH-1:0]);
        end
        return mask;
    endfunction

    bpfa_low_zero #(.W(WORD_BITS)) u_sum_zero
    (
        .word  (sm_rdata_reg),
        .found (s_found),
        .pos   (s_pos)
    );

    bpfa_low_zero #(.W(WORD_BITS)) u_word_zero
    (
        .word  (bm_rdata_reg),
        .found (b_found),
        .pos   (b_pos)
    );

    assign top_lim = (LW'(top_reg) > LW'(NUM_FRAMES)) ? LW'(NUM_FRAMES) : LW'(top_reg);
    assign res_lim = (LW'(reserved_reg) > LW'(NUM_FRAMES)) ? LW'(NUM_FRAMES)
                                                           : LW'(reserved_reg);

    assign cand_word   = {sidx_reg, s_pos};
    assign cand_frame  = {word_reg, b_pos};
    assign cand_faddr  = FAW'(cand_frame) << FRAME_SHIFT;
    assign bm_set_word = bm_rdata_reg | (WORD_BITS'(1) << b_pos);
    assign free_idx    = LW'(address[ADDR_W-1:FRAME_SHIFT]);
    assign free_frame  = FIW'(address[ADDR_W-1:FRAME_SHIFT]);
    assign free_word   = SWW'(free_frame[FIW-1:WSH]);
    assign sweep_base  = LW'(sweep_reg) << WSH;

    assign req_stall       = (state_reg != S_IDLE);
    assign cfg_ready       = 1'b1;
    assign rsp_valid       = rsp_valid_reg;
    assign frame_address   = rsp_faddr_reg;
    assign status          = rsp_status_reg;
    assign allocated_count = rsp_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        sweep_lim_next  = sweep_lim_reg;
        sidx_next       = sidx_reg;
        slot_next       = slot_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        count_next      = count_reg;
        res_faddr_next  = res_faddr_reg;
        res_status_next = res_status_reg;
        reserved_next   = reserved_reg;
        top_next        = top_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_faddr_next  = rsp_faddr_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;

        bm_we    = 1'b0;
        bm_waddr = sweep_reg;
        bm_wdata = '0;
        sm_we    = 1'b0;
        sm_waddr = sidx_reg;
        sm_wdata = '0;
        // hold read addresses so read data stays valid across states
        bm_raddr = word_reg;
        sm_raddr = sidx_reg;

        if (cfg_valid)
        begin
            if (cfg_index == CFG_RESERVED)
            begin
                reserved_next = cfg_data;
            end
            else if (cfg_index == CFG_TOP)
            begin
                top_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_CLEAR, S_INIT:
            begin
                bm_we    = 1'b1;
                bm_waddr = sweep_reg;
                bm_wdata = head_mask(sweep_lim_reg, sweep_base);
                if (EW'(sweep_reg) < EW'(NUM_SWORDS))
                begin
                    sm_we    = 1'b1;
                    sm_waddr = SA'(sweep_reg);
                    sm_wdata = head_mask(sweep_lim_reg >> WSH, sweep_base);
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == WA'(NUM_WORDS - 1))
                begin
                    sweep_next      = '0;
                    res_faddr_next  = '0;
                    res_status_next = STATUS_OK;
                    state_next      = (state_reg == S_CLEAR) ? S_IDLE : S_DONE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_faddr_next  = '0;
                    res_status_next = STATUS_OK;
                    unique case (operation)
                        OP_INIT:
                        begin
                            sweep_next     = '0;
                            sweep_lim_next = res_lim;
                            count_next     = '0;
                            state_next     = S_INIT;
                        end
                        OP_ALLOC:
                        begin
                            sidx_next  = '0;
                            sm_raddr   = '0;
                            state_next = S_SCAN;
                        end
                        OP_FREE:
                        begin
                            if (free_idx >= top_lim)
                            begin
                                res_status_next = STATUS_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                word_next  = free_frame[FIW-1:WSH];
                                bit_next   = free_frame[WSH-1:0];
                                sidx_next  = free_word[SWW-1:WSH];
                                slot_next  = free_word[WSH-1:0];
                                bm_raddr   = free_frame[FIW-1:WSH];
                                sm_raddr   = free_word[SWW-1:WSH];
                                state_next = S_FREE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!s_found)
                begin
                    if (sidx_reg == SA'(NUM_SWORDS - 1))
                    begin
                        res_status_next = STATUS_OOM;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        sidx_next = sidx_reg + 1'b1;
                        sm_raddr  = sidx_reg + 1'b1;
                    end
                end
                else if ((EW'(cand_word) >= EW'(NUM_WORDS)) ||
                         ((EW'(cand_word) << WSH) >= EW'(top_lim)))
                begin
                    res_status_next = STATUS_OOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    word_next  = WA'(cand_word);
                    slot_next  = s_pos;
                    bm_raddr   = WA'(cand_word);
                    state_next = S_WORD;
                end
            end

            S_WORD:
            begin
                // tail word past the last frame can show clear bits
                if (!b_found || (LW'(cand_frame) >= top_lim))
                begin
                    res_status_next = STATUS_OOM;
                end
                else
                begin
                    bm_we    = 1'b1;
                    bm_waddr = word_reg;
                    bm_wdata = bm_set_word;
                    if (&bm_set_word)
                    begin
                        sm_we    = 1'b1;
                        sm_waddr = sidx_reg;
                        sm_wdata = sm_rdata_reg | (WORD_BITS'(1) << slot_reg);
                    end
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    res_faddr_next = cand_faddr[ADDR_W-1:0];
                end
                state_next = S_DONE;
            end

            S_FREE:
            begin
                bm_we    = 1'b1;
                bm_waddr = word_reg;
                bm_wdata = bm_rdata_reg & ~(WORD_BITS'(1) << bit_reg);
                sm_we    = 1'b1;
                sm_waddr = sidx_reg;
                sm_wdata = sm_rdata_reg & ~(WORD_BITS'(1) << slot_reg);
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_faddr_next  = res_faddr_reg;
                    rsp_status_next = res_status_reg;
                    rsp_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            sweep_reg      <= '0;
            sweep_lim_reg  <= '0;
            sidx_reg       <= '0;
            slot_reg       <= '0;
            word_reg       <= '0;
            bit_reg        <= '0;
            count_reg      <= '0;
            res_faddr_reg  <= '0;
            res_status_reg <= STATUS_OK;
            reserved_reg   <= RESERVED_RESET;
            top_reg        <= TOP_RESET;
            rsp_valid_reg  <= 1'b0;
            rsp_faddr_reg  <= '0;
            rsp_status_reg <= STATUS_OK;
            rsp_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            sweep_lim_reg  <= sweep_lim_next;
            sidx_reg       <= sidx_next;
            slot_reg       <= slot_next;
            word_reg       <= word_next;
            bit_reg        <= bit_next;
            count_reg      <= count_next;
            res_faddr_reg  <= res_faddr_next;
            res_status_reg <= res_status_next;
            reserved_reg   <= reserved_next;
            top_reg        <= top_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_faddr_reg  <= rsp_faddr_next;
            rsp_status_reg <= rsp_status_next;
            rsp_count_reg  <= rsp_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bitmap_mem[bm_waddr] <= bm_wdata;
        end
        bm_rdata_reg <= bitmap_mem[bm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            summary_mem[sm_waddr] <= sm_wdata;
        end
        sm_rdata_reg <= summary_mem[sm_raddr];
    end

endmodule

/* hw/rtl/bpfa_checker.sv */
`include "bitmap_page_frame_allocator_assert.svh"

module bpfa_checker
    import bpfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  logic [ADDR_W-1:0]    frame_address,
    input  logic [1:0]           status,
    input  logic [COUNT_W-1:0]   allocated_count
);

    // a waiting result beat holds
    `BPFA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
        rsp_valid && $stable(frame_address) && $stable(status) && $stable(allocated_count))

    // one item at a time: engine is busy right after an accepted beat
    `BPFA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)

    `BPFA_ASSERT_IMP(a_page_aligned, clk, rst_n, rsp_valid, frame_address[FRAME_SHIFT-1:0] == '0)

    // failed items never report a frame
    `BPFA_ASSERT_IMP(a_fail_no_addr, clk, rst_n, rsp_valid && status != STATUS_OK,
        frame_address == '0)

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import bpfa_pkg::*;

    localparam int MAP_WORDS    = BPFA_NUM_FRAMES / BPFA_WORD_BITS;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DIR_ROWS     = 34;

    // codes the package leaves unnamed
    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  faddr;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
    } alloc_result_t;

    typedef enum logic [1:0] {
        ROW_TYPED,
        ROW_PREDICTED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        code;     // operation, or register index for ROW_CFG
        logic [ADDR_W-1:0] value;    // address, or write data for ROW_CFG
        alloc_result_t     result;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic [1:0]           operation;
    logic [ADDR_W-1:0]    address;
    logic                 rsp_valid;
    logic                 rsp_stall;
    logic [ADDR_W-1:0]    frame_address;
    logic [1:0]           status;
    logic [COUNT_W-1:0]   allocated_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // typed-in expectation travelling with the request beat
    logic          beat_typed;
    alloc_result_t beat_result;

    // allocator mirror
    logic [BPFA_WORD_BITS-1:0] frame_map [MAP_WORDS];
    logic [COUNT_W-1:0]        mirror_count;
    logic [CFG_W-1:0]          mirror_reserved;
    logic [CFG_W-1:0]          mirror_top;

    alloc_result_t pending_results [$];
    int            items_sent;
    int            results_seen;
    int            mismatches;
    bit            burst_mode;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h0,       STATUS_OK,    16'd1}},
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h1000,    STATUS_OK,    16'd2}},
        '{ROW_TYPED,     OP_FREE,      27'hFFF,     '{27'h0,       STATUS_OK,    16'd1}},
        '{ROW_TYPED,     OP_FREE,      27'h0,       '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_TYPED,     OP_FREE,      27'h0,       '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_TYPED,     OP_UNUSED,    27'h7FFFFFF, '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_TYPED,     OP_FREE,      27'h7FFFFFF, '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h0,       STATUS_OK,    16'd1}},
        '{ROW_TYPED,     OP_INIT,      27'h0,       '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h400000,  STATUS_OK,    16'd1}},
        '{ROW_CFG,       CFG_TOP,      27'd1026,    '0},
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h401000,  STATUS_OK,    16'd2}},
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h0,       STATUS_OOM,   16'd2}},
        '{ROW_TYPED,     OP_FREE,      27'h402000,  '{27'h0,       STATUS_RANGE, 16'd2}},
        '{ROW_TYPED,     OP_FREE,      27'h401ABC,  '{27'h0,       STATUS_OK,    16'd1}},
        '{ROW_PREDICTED, OP_ALLOC,     27'h0,       '0},
        '{ROW_CFG,       CFG_RESERVED, 27'h0,       '0},
        '{ROW_CFG,       CFG_TOP,      27'h0,       '0},
        '{ROW_TYPED,     OP_INIT,      27'h0,       '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h0,       STATUS_OOM,   16'd0}},
        '{ROW_TYPED,     OP_FREE,      27'h0,       '{27'h0,       STATUS_RANGE, 16'd0}},
        '{ROW_CFG,       CFG_RESERVED, 27'hFFFF,    '0},
        '{ROW_CFG,       CFG_TOP,      27'hFFFF,    '0},
        '{ROW_TYPED,     OP_INIT,      27'h0,       '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h0,       STATUS_OOM,   16'd0}},
        '{ROW_TYPED,     OP_FREE,      27'h7FFFFFF, '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_TYPED,     OP_ALLOC,     27'h0,       '{27'h7FFF000, STATUS_OK,    16'd1}},
        '{ROW_CFG,       CFG_SPARE2,   27'hFFFF,    '0},
        '{ROW_CFG,       CFG_SPARE3,   27'h5A5A,    '0},
        '{ROW_CFG,       CFG_RESERVED, 27'h8000,    '0},
        '{ROW_CFG,       CFG_TOP,      27'h8000,    '0},
        '{ROW_TYPED,     OP_INIT,      27'h0,       '{27'h0,       STATUS_OK,    16'd0}},
        '{ROW_PREDICTED, OP_ALLOC,     27'h0,       '0},
        '{ROW_PREDICTED, OP_UNUSED,    27'h5555555, '0}
    };

    bitmap_page_frame_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .operation       (operation),
        .address         (address),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .frame_address   (frame_address),
        .status          (status),
        .allocated_count (allocated_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int frame_limit(input logic [CFG_W-1:0] v);
        return (v < BPFA_NUM_FRAMES) ? int'(v) : BPFA_NUM_FRAMES;
    endfunction

    // Advances the mirror by one request beat and returns its result.
    function automatic alloc_result_t allocate_or_free(input logic [1:0] op,
                                                       input logic [ADDR_W-1:0] addr);
        alloc_result_t r;
        int lim;
        int idx;
        int w;
        int b;
        r = '0;
        r.status = STATUS_OK;
        case (op)
            OP_INIT:
            begin
                lim = frame_limit(mirror_reserved);
                for (w = 0; w < MAP_WORDS; w++)
                    frame_map[w] = '0;
                for (idx = 0; idx < lim; idx++)
                    frame_map[idx / BPFA_WORD_BITS][idx % BPFA_WORD_BITS] = 1'b1;
                mirror_count = '0;
            end
            OP_ALLOC:
            begin
                lim = frame_limit(mirror_top);
                idx = lim;
                for (w = 0; w < MAP_WORDS && w * BPFA_WORD_BITS < lim && idx == lim; w++)
                begin
                    if (frame_map[w] != '1)
                    begin
                        for (b = 0; b < BPFA_WORD_BITS && idx == lim; b++)
                        begin
                            if (w * BPFA_WORD_BITS + b < lim && !frame_map[w][b])
                                idx = w * BPFA_WORD_BITS + b;
                        end
                    end
                end
                if (idx >= lim)
                    r.status = STATUS_OOM;
                else
                begin
                    frame_map[idx / BPFA_WORD_BITS][idx % BPFA_WORD_BITS] = 1'b1;
                    if (mirror_count != '1)
                        mirror_count++;
                    r.faddr = ADDR_W'(idx * 4096);
                end
            end
            OP_FREE:
            begin
                idx = int'(addr[ADDR_W-1:FRAME_SHIFT]);
                if (idx >= frame_limit(mirror_top))
                    r.status = STATUS_RANGE;
                else
                begin
                    // clearing an already clear frame still lowers the count
                    frame_map[idx / BPFA_WORD_BITS][idx % BPFA_WORD_BITS] = 1'b0;
                    if (mirror_count != '0)
                        mirror_count--;
                end
            end
            default:
            begin
            end
        endcase
        r.count = mirror_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        int w;
        if (!rst_n)
        begin
            for (w = 0; w < MAP_WORDS; w++)
                frame_map[w] = '0;
            mirror_count    = '0;
            mirror_reserved = RESERVED_RESET;
            mirror_top      = TOP_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RESERVED)
                    mirror_reserved = cfg_data;
                else if (cfg_index == CFG_TOP)
                    mirror_top = cfg_data;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, frame_address", frame_address, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (frame_address !== want.faddr)
                        report_mismatch("frame_address", frame_address, want.faddr);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (allocated_count !== want.count)
                        report_mismatch("allocated_count", allocated_count, want.count);
                end
                results_seen++;
            end
            if (req_valid && !req_stall)
            begin
                want = allocate_or_free(operation, address);
                pending_results.push_back(beat_typed ? beat_result : want);
            end
        end
    end

    // response back-pressure: short stalls, an occasional long one, long open stretches
    initial
    begin : rsp_pacing
        int run_left;
        bit hold;
        run_left = 0;
        hold = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                hold = !hold;
                if (hold)
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
                else
                    run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                          : $urandom_range(1, 6);
            end
            rsp_stall <= hold;
            run_left--;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called at a rising edge; returns at the edge that accepted the beat, or after the gap.
    task automatic send_beat(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic typed, input alloc_result_t result);
        int gap;
        req_valid   <= 1'b1;
        operation   <= op;
        address     <= addr;
        beat_typed  <= typed;
        beat_result <= result;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int random_goal;
        int phase_res;
        int phase_top;
        int phase_len;
        int pick;
        int frame;
        int lo;
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        operation   <= OP_INIT;
        address     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_RESERVED;
        cfg_data    <= '0;
        beat_typed  <= 1'b0;
        beat_result <= '0;
        items_sent   = 0;
        results_seen = 0;
        mismatches   = 0;
        burst_mode   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(directed_rows[i].code, directed_rows[i].value[CFG_W-1:0]);
            end
            else
                send_beat(directed_rows[i].code, directed_rows[i].value,
                          directed_rows[i].kind == ROW_TYPED, directed_rows[i].result);
        end

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                phase_res = $urandom_range(0, 300);
            else if (pick < 15)
                phase_res = 1024;
            else if (pick < 17)
                phase_res = $urandom_range(301, 4000);
            else if (pick == 17)
                phase_res = 0;
            else if (pick == 18)
                phase_res = BPFA_NUM_FRAMES;
            else
                phase_res = 65535;

            // a tight top limit makes the pool run dry
            pick = $urandom_range(0, 9);
            if (pick < 4)
                phase_top = phase_res + $urandom_range(1, 64);
            else if (pick < 6)
                phase_top = phase_res + $urandom_range(100, 400);
            else if (pick < 8)
                phase_top = BPFA_NUM_FRAMES;
            else if (pick == 8)
                phase_top = 65535;
            else
                phase_top = $urandom_range(0, 65535);
            if (phase_top > 65535)
                phase_top = 65535;

            drain();
            write_reg(CFG_RESERVED, CFG_W'(phase_res));
            write_reg(CFG_TOP, CFG_W'(phase_top));
            burst_mode = ($urandom_range(0, 3) == 0);
            // a fully reserved map makes every alloc scan the whole summary
            phase_len = (phase_res >= BPFA_NUM_FRAMES) ? 12 : $urandom_range(60, 120);
            if ($urandom_range(0, 9) != 0)
                send_beat(OP_INIT, ADDR_W'($urandom), 1'b0, '0);

            repeat (phase_len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_beat(OP_ALLOC, ADDR_W'($urandom), 1'b0, '0);
                else if (pick < 85)
                begin
                    // frees land around the region being handed out
                    frame = (phase_res < BPFA_NUM_FRAMES) ? phase_res : BPFA_NUM_FRAMES - 1;
                    lo = (frame > 16) ? frame - 16 : 0;
                    frame = $urandom_range(lo, lo + 120);
                    if (frame >= BPFA_NUM_FRAMES)
                        frame = BPFA_NUM_FRAMES - 1;
                    send_beat(OP_FREE, {15'(frame), 12'($urandom_range(0, 4095))}, 1'b0, '0);
                end
                else if (pick < 91)
                    send_beat(OP_FREE, ADDR_W'($urandom), 1'b0, '0);
                else if (pick < 95)
                    send_beat(OP_UNUSED, ADDR_W'($urandom), 1'b0, '0);
                else if (pick < 98)
                    send_beat(OP_INIT, ADDR_W'($urandom), 1'b0, '0);
                else
                begin
                    // free right at or just under the top limit
                    frame = (phase_top < BPFA_NUM_FRAMES) ? phase_top : BPFA_NUM_FRAMES - 1;
                    frame = frame - $urandom_range(0, 1);
                    if (frame < 0)
                        frame = 0;
                    send_beat(OP_FREE, {15'(frame), 12'($urandom_range(0, 4095))}, 1'b0, '0);
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never returned, count", 0, pending_results.size());
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bpfa_pkg.sv
hw/rtl/bpfa_low_zero.sv
hw/rtl/bitmap_page_frame_allocator.sv
hw/rtl/bpfa_checker.sv
dv/testbench.sv
